@@ sv/rbd_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// rbd_pkg
// Shared types and constants for the ring buffer deque: request codes and
// the packed request and result words.
// ============================================================================
package rbd_pkg;

    // Fixed field widths of the request and result words.
    localparam int ACTION_W = 2;
    localparam int DATA_W   = 32;
    localparam int COUNT_W  = 5;
    localparam int CFG_W    = 5;

    // Request codes.
    localparam logic [ACTION_W-1:0] ACT_PUSH_REAR = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_POP_FRONT = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_POP_REAR  = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_STATUS    = 2'd3;

    typedef struct packed {
        logic [ACTION_W-1:0]      action;
        logic signed [DATA_W-1:0] push_value;
    } rbd_req_t;

    typedef struct packed {
        logic                     accepted;
        logic signed [DATA_W-1:0] popped_value;
        logic [COUNT_W-1:0]       count_before_pop;
        logic [COUNT_W-1:0]       count_now;
        logic                     is_empty;
        logic                     is_full;
        logic signed [DATA_W-1:0] front_word;
        logic signed [DATA_W-1:0] rear_word;
    } rbd_rsp_t;

endpackage

@@ sv/rbd_ram.sv @@
`timescale 1ns / 1ps
// ============================================================================
// rbd_ram
// Generic simple dual-port RAM: one write port, one read port with the
// read data registered.
// ============================================================================
module rbd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ sv/ring_buffer_deque.sv @@
`timescale 1ns / 1ps
// ============================================================================
// ring_buffer_deque
// Circular buffer of signed words used as a double-ended queue.
// ============================================================================
// Usage:
// Requests arrive as words on the in channel (valid/ready). Each request
// pushes a word at the rear, pops the front, pops the rear, or asks for
// status. Every request produces exactly one result word on the out channel
// (valid/ready) with the success flag, the popped word, the occupancy and the
// words at both ends after the request.
// The slots live in a RAM with registered read data. The front and rear
// words are cached in registers, so a pop returns its word at once and only
// the new end word has to be fetched from the RAM in the cycle after the
// request is taken. A result passes through the fetch stage, the holding
// register and the output register on its way to the out channel, and no
// new request is taken while the previous one is still in the fetch stage.
// When the receiver stalls, one further request is still taken and its
// result parks in a holding register behind the output register; after that
// in_ready stays low until the output drains.
// Reset empties the buffer and sets the capacity to 16 slots (or MAX_SLOTS
// if smaller). Writing the capacity register also empties the buffer; the
// RAM contents are kept but are no longer reachable.
// ============================================================================
module ring_buffer_deque
    import rbd_pkg::*;
#(
    parameter int MAX_SLOTS = 16,
    parameter int WORD_BITS = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  rbd_req_t         in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output rbd_rsp_t         out_data,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam int IDX_W     = $clog2(MAX_SLOTS);
    localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
    localparam int CAP_RESET = (MAX_SLOTS < 16) ? MAX_SLOTS : 16;

    // Buffer state. The pointers always stay below the capacity.
    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] occ_reg, occ_next;
    logic [CNT_W-1:0] cap_reg, cap_next;

    // Cached end words. While the buffer is not empty they hold the slots at
    // the head and at the tail pointer.
    logic signed [WORD_BITS-1:0] front_reg, front_next;
    logic signed [WORD_BITS-1:0] rear_reg, rear_next;

    // Fetch stage: the request taken in the previous cycle, waiting for the
    // RAM to return the new end word.
    logic                     busy_reg, busy_next;
    logic                     fetch_front_reg, fetch_front_next;
    logic                     fetch_rear_reg, fetch_rear_next;
    logic                     pend_acc_reg, pend_acc_next;
    logic signed [DATA_W-1:0] pend_pop_reg, pend_pop_next;
    logic [COUNT_W-1:0]       pend_before_reg, pend_before_next;

    // Holding register and output register.
    logic     res_valid_reg, res_valid_next;
    rbd_rsp_t res_reg, res_next;
    logic     out_valid_reg, out_valid_next;
    rbd_rsp_t out_reg, out_next;

    // RAM ports.
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic                 ram_re;
    logic [IDX_W-1:0]     ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata;

    logic                        accept;
    logic                        out_free;
    logic                        res_free;
    logic [CNT_W-1:0]            head_inc;
    logic [CNT_W-1:0]            tail_inc;
    logic [IDX_W-1:0]            head_fwd;
    logic [IDX_W-1:0]            tail_fwd;
    logic [IDX_W-1:0]            tail_back;
    logic [CNT_W-1:0]            cap_cfg;
    logic signed [WORD_BITS-1:0] push_word;
    logic                        is_full_now;
    logic                        is_empty_now;

    // The output register frees when it is empty or being read. The holding
    // register frees when it is empty or moving into the output register.
    assign out_free = !out_valid_reg || out_ready;
    assign res_free = !res_valid_reg || out_free;

    // A request is taken only when the fetch stage is idle and its result is
    // sure to find the holding register free when it leaves the fetch stage.
    assign in_ready = !busy_reg && res_free;
    assign accept   = in_valid && in_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Pointer steps with wrap at the capacity in use.
    assign head_inc  = CNT_W'(head_reg) + CNT_W'(1);
    assign tail_inc  = CNT_W'(tail_reg) + CNT_W'(1);
    assign head_fwd  = (head_inc >= cap_reg) ? '0 : IDX_W'(head_inc);
    assign tail_fwd  = (tail_inc >= cap_reg) ? '0 : IDX_W'(tail_inc);
    assign tail_back = (tail_reg == '0) ? IDX_W'(cap_reg - CNT_W'(1))
                                        : tail_reg - IDX_W'(1);

    assign push_word    = WORD_BITS'($signed(in_data.push_value));
    assign is_full_now  = (occ_reg >= cap_reg);
    assign is_empty_now = (occ_reg == '0);

    // A capacity of zero means one slot; anything above the RAM depth means
    // the whole RAM.
    always_comb
    begin
        if (cfg_data == '0)
        begin
            cap_cfg = CNT_W'(1);
        end
        else if (int'(cfg_data) > MAX_SLOTS)
        begin
            cap_cfg = CNT_W'(MAX_SLOTS);
        end
        else
        begin
            cap_cfg = CNT_W'(cfg_data);
        end
    end

    // Request handling and state update.
    always_comb
    begin
        head_next        = head_reg;
        tail_next        = tail_reg;
        occ_next         = occ_reg;
        cap_next         = cap_reg;
        front_next       = front_reg;
        rear_next        = rear_reg;
        busy_next        = 1'b0;
        fetch_front_next = 1'b0;
        fetch_rear_next  = 1'b0;
        pend_acc_next    = pend_acc_reg;
        pend_pop_next    = pend_pop_reg;
        pend_before_next = pend_before_reg;
        ram_we           = 1'b0;
        ram_waddr        = tail_fwd;
        ram_wdata        = push_word;
        ram_re           = 1'b0;
        ram_raddr        = tail_back;

        // Fetch stage of a pop: the RAM returns the new end word.
        if (busy_reg)
        begin
            if (fetch_front_reg)
            begin
                front_next = ram_rdata;
            end
            if (fetch_rear_reg)
            begin
                rear_next = ram_rdata;
            end
        end

        if (accept)
        begin
            busy_next        = 1'b1;
            pend_acc_next    = 1'b1;
            pend_pop_next    = '0;
            pend_before_next = '0;
            case (in_data.action)
                ACT_PUSH_REAR:
                begin
                    if (is_full_now)
                    begin
                        pend_acc_next = 1'b0;
                    end
                    else
                    begin
                        ram_we    = 1'b1;
                        tail_next = tail_fwd;
                        occ_next  = occ_reg + CNT_W'(1);
                        rear_next = push_word;
                        if (is_empty_now)
                        begin
                            front_next = push_word;
                        end
                    end
                end
                ACT_POP_FRONT:
                begin
                    if (is_empty_now)
                    begin
                        pend_acc_next = 1'b0;
                    end
                    else
                    begin
                        pend_pop_next    = DATA_W'(front_reg);
                        pend_before_next = COUNT_W'(occ_reg);
                        head_next        = head_fwd;
                        occ_next         = occ_reg - CNT_W'(1);
                        ram_re           = 1'b1;
                        ram_raddr        = head_fwd;
                        fetch_front_next = 1'b1;
                    end
                end
                ACT_POP_REAR:
                begin
                    if (is_empty_now)
                    begin
                        pend_acc_next = 1'b0;
                    end
                    else
                    begin
                        pend_pop_next   = DATA_W'(rear_reg);
                        tail_next       = tail_back;
                        occ_next        = occ_reg - CNT_W'(1);
                        ram_re          = 1'b1;
                        ram_raddr       = tail_back;
                        fetch_rear_next = 1'b1;
                    end
                end
                default:
                begin
                    // Status only: nothing changes.
                end
            endcase
        end

        // A capacity write empties the buffer.
        if (cfg_we)
        begin
            cap_next  = cap_cfg;
            head_next = '0;
            tail_next = IDX_W'(cap_cfg - CNT_W'(1));
            occ_next  = '0;
        end
    end

    // Result assembly at the end of the fetch cycle, from the updated state.
    always_comb
    begin
        res_valid_next = res_valid_reg && !out_free;
        res_next       = res_reg;
        if (busy_reg)
        begin
            res_valid_next            = 1'b1;
            res_next.accepted         = pend_acc_reg;
            res_next.popped_value     = pend_pop_reg;
            res_next.count_before_pop = pend_before_reg;
            res_next.count_now        = COUNT_W'(occ_reg);
            res_next.is_empty         = is_empty_now;
            res_next.is_full          = (occ_reg == cap_reg);
            res_next.front_word       = is_empty_now ? '0 : DATA_W'(front_next);
            res_next.rear_word        = is_empty_now ? '0 : DATA_W'(rear_next);
        end

        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        if (res_valid_reg && out_free)
        begin
            out_valid_next = 1'b1;
            out_next       = res_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg        <= '0;
            tail_reg        <= IDX_W'(CAP_RESET - 1);
            occ_reg         <= '0;
            cap_reg         <= CNT_W'(CAP_RESET);
            busy_reg        <= 1'b0;
            fetch_front_reg <= 1'b0;
            fetch_rear_reg  <= 1'b0;
            res_valid_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            head_reg        <= head_next;
            tail_reg        <= tail_next;
            occ_reg         <= occ_next;
            cap_reg         <= cap_next;
            busy_reg        <= busy_next;
            fetch_front_reg <= fetch_front_next;
            fetch_rear_reg  <= fetch_rear_next;
            res_valid_reg   <= res_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        front_reg       <= front_next;
        rear_reg        <= rear_next;
        pend_acc_reg    <= pend_acc_next;
        pend_pop_reg    <= pend_pop_next;
        pend_before_reg <= pend_before_next;
        res_reg         <= res_next;
        out_reg         <= out_next;
    end

    rbd_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAX_SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

@@ sv/rbd_checker.sv @@
`timescale 1ns / 1ps
// ============================================================================
// rbd_checker
// Port-level checks for the ring buffer deque, bound to the top level.
// ============================================================================
module rbd_checker
    import rbd_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     in_valid,
    input logic     in_ready,
    input logic     out_valid,
    input logic     out_ready,
    input rbd_rsp_t out_data
);

    // Only one request is in the fetch stage at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("rbd: request taken in the cycle after another request");

    // An empty buffer reports zero occupancy and zero end words.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.is_empty |->
            out_data.count_now == '0 && out_data.front_word == '0 &&
            out_data.rear_word == '0)
    else $error("rbd: empty result carries data");

    // The capacity is at least one, so empty and full never coincide.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.is_empty && out_data.is_full))
    else $error("rbd: result both empty and full");

    // A nonzero front-pop count only comes with a successful pop.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.count_before_pop != '0 |->
            out_data.accepted && out_data.count_now + 5'd1 == out_data.count_before_pop)
    else $error("rbd: front-pop count inconsistent");

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("rbd: stalled result changed");

endmodule

bind ring_buffer_deque rbd_checker u_rbd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
